[design/jps_pkg.sv]
// ----------------------------------------------------------------------------
// jps_pkg
// Shared constants for the jump point search step: grid size defaults,
// operation codes, configuration register indexes and the goal field width.
// ----------------------------------------------------------------------------
package jps_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int GOAL_W = 6;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_JUMP  = 2'd1;
    localparam logic [1:0] OP_NBR   = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_GOAL_X = 1'b0;
    localparam logic [0:0] REG_GOAL_Y = 1'b1;

endpackage

[design/jps_map.sv]
// ----------------------------------------------------------------------------
// jps_map
// Walkable-cell bitmap: one write port, one registered read port, and a
// clearing sweep after reset that marks every cell blocked.
// ----------------------------------------------------------------------------
module jps_map #(
    parameter int GRID_WIDTH  = jps_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = jps_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          wr_en,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]     addr,
    input  logic                                          wr_data,
    input  logic                                          rd_en,
    output logic                                          rd_data,
    output logic                                          busy
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);

    logic          mem [DEPTH];
    logic [AW:0]   clr_cnt_reg;
    logic [AW:0]   clr_cnt_next;
    logic          rd_data_reg;

    assign busy = (clr_cnt_reg != DEPTH_C);

    // advance the clearing sweep until every cell is written
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (busy) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port: sweep first, then cell writes
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem[clr_cnt_reg[AW-1:0]] <= 1'b0;
        end else if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/jump_point_search_step.sv]
// ----------------------------------------------------------------------------
// jump_point_search_step
// Grid bitmap with diagonal and straight-line jump and pruned-successor queries,
// evaluated one bitmap read at a time under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  cfg       in         cfg_wr_en          cfg_index, cfg_data
//  s_        in         s_valid / s_ready  operation, cell, from, has_parent, walkable
//  m_        out        m_valid / m_ready  found, out_x, out_y, last
//
//  Each bitmap probe issues its address, then reads the registered data, on the
//  single read port. A jump makes 5 probes per open scanned cell and 1 per
//  blocked one; a neighbour query makes 3, 5 or 8 probes; a cell write makes
//  none. After reset the bitmap is swept to blocked, with s_ready low.
//  A stalled m_ channel holds the sequencer at its next push.
// ----------------------------------------------------------------------------
module jump_point_search_step #(
    parameter int GRID_WIDTH  = jps_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = jps_pkg::GRID_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [5:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic signed [7:0] s_cell_x,
    input  logic signed [7:0] s_cell_y,
    input  logic signed [7:0] s_from_x,
    input  logic signed [7:0] s_from_y,
    input  logic              s_has_parent,
    input  logic              s_walkable,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic signed [7:0] m_out_x,
    output logic signed [7:0] m_out_y,
    output logic              m_last
);

    localparam int MAXD = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
    localparam int CW   = (($clog2(MAXD) > 8) ? $clog2(MAXD) : 8) + 2;
    localparam int AW   = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int GW   = jps_pkg::GOAL_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_ISSUE  = 5'b00100,
        ST_EVAL   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef enum logic [4:0] {
        PH_LINE = 5'b00001,
        PH_DIAG = 5'b00010,
        PH_SUBH = 5'b00100,
        PH_SUBV = 5'b01000,
        PH_ZERO = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        NB_ALL  = 4'b0001,
        NB_DIAG = 4'b0010,
        NB_VERT = 4'b0100,
        NB_HORZ = 4'b1000
    } nb_mode_t;

    function automatic logic signed [CW-1:0] ext2(input logic [1:0] o);
        return {{(CW-2){o[1]}}, o};
    endfunction

    function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
        return {{(CW-8){v[7]}}, v};
    endfunction

    function automatic logic [1:0] sgn(input logic signed [CW-1:0] v);
        if (v == '0) begin
            return 2'b00;
        end else if (v[CW-1]) begin
            return 2'b11;
        end
        return 2'b01;
    endfunction

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    nb_mode_t              mode_reg, mode_next;
    logic [GW-1:0]         goal_x_reg, goal_y_reg;
    logic [1:0]            op_reg, op_next;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic [1:0]            dx_reg, dx_next, dy_reg, dy_next;
    logic                  hp_reg, hp_next, wk_reg, wk_next;
    logic signed [CW-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0]  lx_reg, lx_next, ly_reg, ly_next;
    logic [1:0]            ldx_reg, ldx_next, ldy_reg, ldy_next;
    logic [2:0]            p_reg, p_next;
    logic [2:0]            b_reg, b_next;
    logic [2:0]            k_reg, k_next;
    logic                  inr_reg, inr_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic signed [CW-1:0]  pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg, m_found_next;
    logic [7:0]            m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic                  m_last_reg, m_last_next;

    logic                  map_busy, map_rd_data, map_wr_en, map_rd_en;
    logic [AW-1:0]         map_addr;

    logic signed [CW-1:0]  base_x, base_y, probe_x, probe_y;
    logic [1:0]            jo_x, jo_y;
    logic [1:0]            nb_px, nb_py, nb_ex, nb_ey;
    logic                  nb_inv;
    logic [2:0]            nb_last_k;
    logic                  probe_inr, cell_open, goal_hit, hit, forced;
    logic                  can_push, push;
    logic                  push_found, push_last;
    logic [7:0]            push_x, push_y;
    logic signed [CW-1:0]  sx, sy, spx, spy;

    assign sx  = ext8(s_cell_x);
    assign sy  = ext8(s_cell_y);
    assign spx = ext8(s_from_x);
    assign spy = ext8(s_from_y);

    assign s_ready  = (state_reg == ST_IDLE) && !map_busy;
    assign can_push = !m_valid_reg || m_ready;

    // jump probe offsets: cell, then the two forced-neighbour pairs
    always_comb begin
        jo_x = 2'b00;
        jo_y = 2'b00;
        if (phase_reg == PH_DIAG) begin
            case (p_reg)
                3'd1: begin jo_x = 2'(-dx_reg); jo_y = dy_reg;        end
                3'd2: begin jo_x = 2'(-dx_reg); jo_y = 2'b00;         end
                3'd3: begin jo_x = dx_reg;      jo_y = 2'(-dy_reg);   end
                3'd4: begin jo_x = 2'b00;       jo_y = 2'(-dy_reg);   end
                default: begin jo_x = 2'b00;    jo_y = 2'b00;         end
            endcase
        end else if (ldx_reg != 2'b00) begin
            case (p_reg)
                3'd1: begin jo_x = ldx_reg; jo_y = 2'b01; end
                3'd2: begin jo_x = 2'b00;   jo_y = 2'b01; end
                3'd3: begin jo_x = ldx_reg; jo_y = 2'b11; end
                3'd4: begin jo_x = 2'b00;   jo_y = 2'b11; end
                default: begin jo_x = 2'b00; jo_y = 2'b00; end
            endcase
        end else begin
            case (p_reg)
                3'd1: begin jo_x = 2'b01; jo_y = ldy_reg; end
                3'd2: begin jo_x = 2'b01; jo_y = 2'b00;   end
                3'd3: begin jo_x = 2'b11; jo_y = ldy_reg; end
                3'd4: begin jo_x = 2'b11; jo_y = 2'b00;   end
                default: begin jo_x = 2'b00; jo_y = 2'b00; end
            endcase
        end
    end

    // successor list: probe offset, invert flag, last list index
    always_comb begin
        nb_px = 2'b00; nb_py = 2'b00; nb_inv = 1'b0;
        nb_last_k = 3'd2;
        case (mode_reg)
            NB_ALL: begin
                nb_last_k = 3'd7;
                case (k_reg)
                    3'd0: begin nb_px = 2'b00; nb_py = 2'b11; end
                    3'd1: begin nb_px = 2'b01; nb_py = 2'b00; end
                    3'd2: begin nb_px = 2'b00; nb_py = 2'b01; end
                    3'd3: begin nb_px = 2'b11; nb_py = 2'b00; end
                    3'd4: begin nb_px = 2'b11; nb_py = 2'b11; end
                    3'd5: begin nb_px = 2'b01; nb_py = 2'b11; end
                    3'd6: begin nb_px = 2'b01; nb_py = 2'b01; end
                    default: begin nb_px = 2'b11; nb_py = 2'b01; end
                endcase
            end
            NB_DIAG: begin
                nb_last_k = 3'd4;
                case (k_reg)
                    3'd0: begin nb_px = 2'b00;  nb_py = dy_reg; end
                    3'd1: begin nb_px = dx_reg; nb_py = 2'b00;  end
                    3'd2: begin nb_px = dx_reg; nb_py = dy_reg; end
                    3'd3: begin nb_px = 2'(-dx_reg); nb_py = 2'b00; nb_inv = 1'b1; end
                    default: begin nb_px = 2'b00; nb_py = 2'(-dy_reg); nb_inv = 1'b1; end
                endcase
            end
            NB_VERT: begin
                case (k_reg)
                    3'd0: begin nb_px = 2'b00; nb_py = dy_reg; end
                    3'd1: begin nb_px = 2'b01; nb_py = 2'b00; nb_inv = 1'b1; end
                    default: begin nb_px = 2'b11; nb_py = 2'b00; nb_inv = 1'b1; end
                endcase
            end
            default: begin
                case (k_reg)
                    3'd0: begin nb_px = dx_reg; nb_py = 2'b00; end
                    3'd1: begin nb_px = 2'b00; nb_py = 2'b01; nb_inv = 1'b1; end
                    default: begin nb_px = 2'b00; nb_py = 2'b11; nb_inv = 1'b1; end
                endcase
            end
        endcase
    end

    // emitted offset: inverted probes move one step along the travel direction
    always_comb begin
        nb_ex = nb_px;
        nb_ey = nb_py;
        if (nb_inv) begin
            case (mode_reg)
                NB_DIAG: begin
                    if (k_reg == 3'd3) begin
                        nb_ex = 2'(-dx_reg); nb_ey = dy_reg;
                    end else begin
                        nb_ex = dx_reg; nb_ey = 2'(-dy_reg);
                    end
                end
                NB_VERT: begin nb_ex = nb_px; nb_ey = dy_reg; end
                NB_HORZ: begin nb_ex = dx_reg; nb_ey = nb_py; end
                default: begin nb_ex = nb_px; nb_ey = nb_py; end
            endcase
        end
    end

    // probe coordinate and bitmap address
    always_comb begin
        if (state_reg == ST_START || op_reg == jps_pkg::OP_NBR) begin
            base_x = x_reg;
            base_y = y_reg;
        end else if (phase_reg == PH_DIAG) begin
            base_x = cx_reg;
            base_y = cy_reg;
        end else begin
            base_x = lx_reg;
            base_y = ly_reg;
        end
        if (state_reg == ST_START) begin
            probe_x = base_x;
            probe_y = base_y;
        end else if (op_reg == jps_pkg::OP_NBR) begin
            probe_x = base_x + ext2(nb_px);
            probe_y = base_y + ext2(nb_py);
        end else begin
            probe_x = base_x + ext2(jo_x);
            probe_y = base_y + ext2(jo_y);
        end
    end

    assign probe_inr = !probe_x[CW-1] && !probe_y[CW-1] &&
                       (probe_x < $signed(CW'(GRID_WIDTH))) &&
                       (probe_y < $signed(CW'(GRID_HEIGHT)));
    assign map_addr  = AW'(AW'($unsigned(probe_y)) * AW'(GRID_WIDTH)
                           + AW'($unsigned(probe_x)));
    assign map_wr_en = (state_reg == ST_START) && (op_reg == jps_pkg::OP_WRITE)
                       && probe_inr;
    assign map_rd_en = (state_reg == ST_ISSUE);

    assign cell_open = inr_reg && map_rd_data;
    assign goal_hit  = (base_x == $signed({{(CW-GW){1'b0}}, goal_x_reg})) &&
                       (base_y == $signed({{(CW-GW){1'b0}}, goal_y_reg}));
    assign hit       = cell_open ^ nb_inv;
    assign forced    = (b_reg[0] && !b_reg[1]) || (b_reg[2] && !cell_open);

    jps_map #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (map_wr_en),
        .addr    (map_addr),
        .wr_data (wk_reg),
        .rd_en   (map_rd_en),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        hp_next         = hp_reg;
        wk_next         = wk_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        lx_next         = lx_reg;
        ly_next         = ly_reg;
        ldx_next        = ldx_reg;
        ldy_next        = ldy_reg;
        p_next          = p_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        inr_next        = inr_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        push            = 1'b0;
        push_found      = pend_valid_reg;
        push_x          = pend_x_reg[7:0];
        push_y          = pend_y_reg[7:0];
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next         = s_operation;
                    x_next          = sx;
                    y_next          = sy;
                    dx_next         = sgn(sx - spx);
                    dy_next         = sgn(sy - spy);
                    hp_next         = s_has_parent;
                    wk_next         = s_walkable;
                    pend_valid_next = 1'b0;
                    state_next      = ST_START;
                end
            end
            ST_START: begin
                p_next = 3'd0;
                k_next = 3'd0;
                lx_next  = x_reg;
                ly_next  = y_reg;
                cx_next  = x_reg;
                cy_next  = y_reg;
                ldx_next = dx_reg;
                ldy_next = dy_reg;
                if (dx_reg != 2'b00 && dy_reg != 2'b00) begin
                    phase_next = PH_DIAG;
                end else if (dx_reg != 2'b00 || dy_reg != 2'b00) begin
                    phase_next = PH_LINE;
                end else begin
                    phase_next = PH_ZERO;
                end
                if (!hp_reg) begin
                    mode_next = NB_ALL;
                end else if (dx_reg != 2'b00 && dy_reg != 2'b00) begin
                    mode_next = NB_DIAG;
                end else if (dx_reg == 2'b00) begin
                    mode_next = NB_VERT;
                end else begin
                    mode_next = NB_HORZ;
                end
                case (op_reg)
                    jps_pkg::OP_JUMP: state_next = ST_ISSUE;
                    jps_pkg::OP_NBR:  state_next = ST_ISSUE;
                    default:          state_next = ST_IDLE;
                endcase
            end
            ST_ISSUE: begin
                inr_next   = probe_inr;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (op_reg == jps_pkg::OP_NBR) begin
                    // emit the held successor once a newer one shows up
                    if (!(hit && pend_valid_reg && !can_push)) begin
                        if (hit) begin
                            push            = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_x_next     = x_reg + ext2(nb_ex);
                            pend_y_next     = y_reg + ext2(nb_ey);
                        end
                        if (k_reg == nb_last_k) begin
                            state_next = ST_FINISH;
                        end else begin
                            k_next     = k_reg + 3'd1;
                            state_next = ST_ISSUE;
                        end
                    end
                end else begin
                    state_next = ST_ISSUE;
                    p_next     = p_reg + 3'd1;
                    if (p_reg == 3'd0 && (!cell_open || phase_reg == PH_ZERO
                                          || goal_hit) && !(cell_open && goal_hit)) begin
                        // blocked cell, or a standing query off the goal
                        p_next = 3'd0;
                        case (phase_reg)
                            PH_SUBH: begin
                                phase_next = PH_SUBV;
                                lx_next    = cx_reg;
                                ly_next    = cy_reg + ext2(dy_reg);
                                ldx_next   = 2'b00;
                                ldy_next   = dy_reg;
                            end
                            PH_SUBV: begin
                                phase_next = PH_DIAG;
                                cx_next    = cx_reg + ext2(dx_reg);
                                cy_next    = cy_reg + ext2(dy_reg);
                            end
                            default: begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end else if ((p_reg == 3'd0 && goal_hit) ||
                                 (p_reg == 3'd4 && forced)) begin
                        // jump point: report scan cell or diagonal origin
                        p_next          = 3'd0;
                        state_next      = ST_FINISH;
                        pend_valid_next = 1'b1;
                        if (phase_reg == PH_LINE || phase_reg == PH_ZERO) begin
                            pend_x_next = lx_reg;
                            pend_y_next = ly_reg;
                        end else begin
                            pend_x_next = cx_reg;
                            pend_y_next = cy_reg;
                        end
                    end else if (p_reg == 3'd4) begin
                        // no stop here: advance the scan
                        p_next = 3'd0;
                        if (phase_reg == PH_DIAG) begin
                            phase_next = PH_SUBH;
                            lx_next    = cx_reg + ext2(dx_reg);
                            ly_next    = cy_reg;
                            ldx_next   = dx_reg;
                            ldy_next   = 2'b00;
                        end else begin
                            lx_next = lx_reg + ext2(ldx_reg);
                            ly_next = ly_reg + ext2(ldy_reg);
                        end
                    end else if (p_reg != 3'd0) begin
                        b_next[p_reg[1:0] - 2'd1] = cell_open;
                    end
                end
            end
            ST_FINISH: begin
                if (can_push) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    if (!pend_valid_reg) begin
                        push_x = 8'd0;
                        push_y = 8'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: load on push, drop on take
    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_last_next  = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_found_next = push_found;
            m_x_next     = push_x;
            m_y_next     = push_y;
            m_last_next  = push_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_ZERO;
            mode_reg       <= NB_ALL;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            mode_reg       <= mode_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en && cfg_index == jps_pkg::REG_GOAL_X) begin
                goal_x_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == jps_pkg::REG_GOAL_Y) begin
                goal_y_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        hp_reg      <= hp_next;
        wk_reg      <= wk_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        lx_reg      <= lx_next;
        ly_reg      <= ly_next;
        ldx_reg     <= ldx_next;
        ldy_reg     <= ldy_next;
        p_reg       <= p_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        inr_reg     <= inr_next;
        pend_x_reg  <= pend_x_next;
        pend_y_reg  <= pend_y_next;
        m_found_reg <= m_found_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_last  = m_last_reg;

    // a push never overwrites a word still waiting on the output
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> can_push)
        else $error("push onto a stalled output word");

    // no pending successor survives into idle
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    // input held off while the bitmap sweep runs
    a_sweep_block: assert property (@(posedge aclk) disable iff (!aresetn)
        map_busy |-> !s_ready)
        else $error("input accepted during bitmap sweep");

    // a word with no find is always the final word of its run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_last_reg)
        else $error("empty result word not marked last");

endmodule

[tb/tb_jump_point_search_step.sv]
// ----------------------------------------------------------------------------
// tb_jump_point_search_step
// Self-checking bench for the grid jump / pruned-successor block: a directed
// table followed by random traffic in three handshake pressure phases, every
// result word checked against a bitmap and goal predictor or the table's value.
// ----------------------------------------------------------------------------
module tb_jump_point_search_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam logic [1:0] OP_NONE = 2'd3;  // undefined code, dropped by the block

    typedef struct packed {
        logic [1:0]        op;
        logic signed [7:0] cx;
        logic signed [7:0] cy;
        logic signed [7:0] fx;
        logic signed [7:0] fy;
        logic              hp;
        logic              wk;
    } query_t;

    typedef struct packed {
        logic              found;
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic              last;
    } hit_t;

    typedef struct packed {
        query_t q;
        logic   typed;
        logic   ef;
        logic signed [7:0] ex;
        logic signed [7:0] ey;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [0:0]        cfg_index;
    logic [5:0]        cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_operation;
    logic signed [7:0] s_cell_x;
    logic signed [7:0] s_cell_y;
    logic signed [7:0] s_from_x;
    logic signed [7:0] s_from_y;
    logic              s_has_parent;
    logic              s_walkable;
    logic              m_valid;
    logic              m_ready;
    logic              m_found;
    logic signed [7:0] m_out_x;
    logic signed [7:0] m_out_y;
    logic              m_last;

    jump_point_search_step dut (.*);

    // predictor state
    bit   grid_open [GW*GH];
    int   goal_col;
    int   goal_row;
    hit_t hits_pending[$];

    int   errors;
    int   words_sent;
    int   words_checked;
    int   jumps_sent;
    int   nbr_sent;
    int   tx_idle;
    int   rx_idle;
    bit   rx_hold_req;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("TIMEOUT at %0t, %0d results outstanding", $time, hits_pending.size());
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic bit open_at(int x, int y);
        if (x < 0 || y < 0 || x >= GW || y >= GH) return 1'b0;
        return grid_open[y*GW + x];
    endfunction

    function automatic bit at_goal(int x, int y);
        return x == goal_col && y == goal_row;
    endfunction

    function automatic bit walk_line(int x, int y, int dx, int dy,
                                     output int rx, output int ry);
        forever begin
            if (!open_at(x, y)) return 1'b0;
            if (at_goal(x, y)) break;
            if (dx != 0) begin
                if ((open_at(x+dx, y+1) && !open_at(x, y+1)) ||
                    (open_at(x+dx, y-1) && !open_at(x, y-1))) break;
            end else begin
                if ((open_at(x+1, y+dy) && !open_at(x+1, y)) ||
                    (open_at(x-1, y+dy) && !open_at(x-1, y))) break;
            end
            x += dx;
            y += dy;
        end
        rx = x;
        ry = y;
        return 1'b1;
    endfunction

    function automatic bit walk_diag(int x, int y, int dx, int dy,
                                     output int rx, output int ry);
        int tx, ty;
        forever begin
            if (!open_at(x, y)) return 1'b0;
            if (at_goal(x, y)) break;
            if ((open_at(x-dx, y+dy) && !open_at(x-dx, y)) ||
                (open_at(x+dx, y-dy) && !open_at(x, y-dy))) break;
            if (walk_line(x+dx, y, dx, 0, tx, ty) || walk_line(x, y+dy, 0, dy, tx, ty))
                break;
            x += dx;
            y += dy;
        end
        rx = x;
        ry = y;
        return 1'b1;
    endfunction

    function automatic int sgn(int v);
        return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    // apply one accepted word: update the bitmap or queue its result run
    function automatic void predict_word(query_t q, output hit_t run[$]);
        int x, y, dx, dy, rx, ry;
        bit hit;
        int ox[8] = '{0, 1, 0, -1, -1, 1, 1, -1};
        int oy[8] = '{-1, 0, 1, 0, -1, -1, 1, 1};
        run = {};
        x  = int'(q.cx);
        y  = int'(q.cy);
        dx = sgn(x - int'(q.fx));
        dy = sgn(y - int'(q.fy));
        case (q.op)
            jps_pkg::OP_WRITE: begin
                if (x >= 0 && y >= 0 && x < GW && y < GH) grid_open[y*GW + x] = q.wk;
                return;
            end
            jps_pkg::OP_JUMP: begin
                if (!open_at(x, y)) hit = 0;
                else if (at_goal(x, y)) begin
                    hit = 1; rx = x; ry = y;
                end else if (dx != 0 && dy != 0) hit = walk_diag(x, y, dx, dy, rx, ry);
                else if (dx != 0 || dy != 0) hit = walk_line(x, y, dx, dy, rx, ry);
                else hit = 0;
                if (hit) run.insert(run.size(), hit_t'{1'b1, 8'(rx), 8'(ry), 1'b0});
            end
            jps_pkg::OP_NBR: begin
                if (!q.hp) begin
                    for (int i = 0; i < 8; i++)
                        if (open_at(x+ox[i], y+oy[i]))
                            run.insert(run.size(),
                                       hit_t'{1'b1, 8'(x+ox[i]), 8'(y+oy[i]), 1'b0});
                end else if (dx != 0 && dy != 0) begin
                    if (open_at(x, y+dy))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x), 8'(y+dy), 1'b0});
                    if (open_at(x+dx, y))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y), 1'b0});
                    if (open_at(x+dx, y+dy))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y+dy), 1'b0});
                    if (!open_at(x-dx, y))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x-dx), 8'(y+dy), 1'b0});
                    if (!open_at(x, y-dy))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y-dy), 1'b0});
                end else if (dx == 0) begin
                    if (open_at(x, y+dy))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x), 8'(y+dy), 1'b0});
                    if (!open_at(x+1, y))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+1), 8'(y+dy), 1'b0});
                    if (!open_at(x-1, y))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x-1), 8'(y+dy), 1'b0});
                end else begin
                    if (open_at(x+dx, y))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y), 1'b0});
                    if (!open_at(x, y+1))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y+1), 1'b0});
                    if (!open_at(x, y-1))
                        run.insert(run.size(), hit_t'{1'b1, 8'(x+dx), 8'(y-1), 1'b0});
                end
            end
            default: return;
        endcase
        if (run.size() == 0) run.insert(0, hit_t'{1'b0, 8'sd0, 8'sd0, 1'b0});
        run[run.size()-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_word(query_t q, bit typed = 0, hit_t typed_hit = '0);
        hit_t run[$];
        if ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= q.op;
        s_cell_x     <= q.cx;
        s_cell_y     <= q.cy;
        s_from_x     <= q.fx;
        s_from_y     <= q.fy;
        s_has_parent <= q.hp;
        s_walkable   <= q.wk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(q, run);
        if (typed && run.size() != 0) run = '{typed_hit};
        foreach (run[i]) hits_pending.insert(hits_pending.size(), run[i]);
        words_sent++;
        if (q.op == jps_pkg::OP_JUMP) jumps_sent++;
        if (q.op == jps_pkg::OP_NBR) nbr_sent++;
    endtask

    // wait for every result, then let a trailing write settle
    task automatic drain();
        s_valid <= 1'b0;
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic set_goal(int col, int row);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= jps_pkg::REG_GOAL_X;
        cfg_data  <= 6'(col);
        @(posedge aclk);
        cfg_index <= jps_pkg::REG_GOAL_Y;
        cfg_data  <= 6'(row);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        goal_col = col;
        goal_row = row;
    endtask

    function automatic logic signed [7:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(0, 15));
        if (r < 90) return 8'($urandom_range(0, 63));
        if (r < 97) begin
            case ($urandom_range(0, 3))
                0: return -8'sd1;
                1: return 8'sd64;
                2: return 8'sd63;
                default: return 8'sd0;
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic query_t random_word(bit writes_only);
        query_t q;
        int r;
        q.cx = pick_coord();
        q.cy = pick_coord();
        q.hp = 1'($urandom);
        q.wk = ($urandom_range(0, 99) < 75);
        if ($urandom_range(0, 9) == 0) begin
            q.fx = 8'($urandom);
            q.fy = 8'($urandom);
        end else begin
            q.fx = q.cx + 8'($urandom_range(0, 2) - 1);
            q.fy = q.cy + 8'($urandom_range(0, 2) - 1);
        end
        r = $urandom_range(0, 99);
        if (writes_only || r < 35) q.op = jps_pkg::OP_WRITE;
        else if (r < 65) q.op = jps_pkg::OP_JUMP;
        else if (r < 96) q.op = jps_pkg::OP_NBR;
        else q.op = OP_NONE;
        return q;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_word(random_word(i < 50));
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hits_pending.size() == 0) begin
                $display("%0t: unexpected result word found=%0d x=%0d y=%0d last=%0d",
                         $time, m_found, m_out_x, m_out_y, m_last);
                errors++;
            end else begin
                want = hits_pending.pop_front();
                words_checked++;
                if (m_found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, m_found);
                    errors++;
                end
                if (m_out_x !== want.x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, want.x, m_out_x);
                    errors++;
                end
                if (m_out_y !== want.y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, want.y, m_out_y);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    row_t plan[] = '{
        // empty map after reset
        '{'{jps_pkg::OP_JUMP,  8'sd0,   8'sd0,    8'sd1,    8'sd1,   1'b0, 1'b0},
          1'b1, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd0,   8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b0},
          1'b1, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd0,   8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        // goal reached at once, also with the parent on the cell
        '{'{jps_pkg::OP_JUMP,  8'sd0,   8'sd0,    8'sd1,    8'sd0,   1'b0, 1'b0},
          1'b1, 1'b1, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_JUMP,  8'sd0,   8'sd0,    8'sd0,    8'sd0,   1'b1, 1'b0},
          1'b1, 1'b1, 8'sd0, 8'sd0},
        // off-grid writes are dropped; then in-grid cells are written
        '{'{jps_pkg::OP_WRITE, -8'sd1,  8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd64,  8'sd64,   8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, -8'sd128, 8'sd127, 8'sd0,    8'sd0,   1'b1, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd1,   8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd1,   8'sd1,    8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd0,   8'sd1,    8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd63,  8'sd63,   8'sd0,    8'sd0,   1'b0, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd63,  8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        // successors: no parent, diagonal, vertical, horizontal, zero step
        '{'{jps_pkg::OP_NBR,   8'sd0,   8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd1,   8'sd1,    8'sd0,    8'sd0,   1'b1, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd1,   8'sd1,    8'sd1,    8'sd0,   1'b1, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd1,   8'sd1,    8'sd0,    8'sd1,   1'b1, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd1,   8'sd1,    8'sd1,    8'sd1,   1'b1, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        // jumps: diagonal, far parent, grid corner; then an undefined code and an off-grid query
        '{'{jps_pkg::OP_JUMP,  8'sd1,   8'sd1,    8'sd0,    8'sd0,   1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_JUMP,  8'sd5,   8'sd1,    8'sd0,    8'sd1,   1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_JUMP,  8'sd63,  8'sd63,   8'sd62,   8'sd62,  1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{OP_NONE,           8'sd1,   8'sd1,    8'sd0,    8'sd0,   1'b1, 1'b1},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_NBR,   8'sd127, -8'sd128, -8'sd128, 8'sd127, 1'b1, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0},
        // parent on an open non-goal cell finds nothing
        '{'{jps_pkg::OP_JUMP,  8'sd1,   8'sd1,    8'sd1,    8'sd1,   1'b0, 1'b0},
          1'b1, 1'b0, 8'sd0, 8'sd0},
        '{'{jps_pkg::OP_WRITE, 8'sd0,   8'sd0,    8'sd0,    8'sd0,   1'b0, 1'b0},
          1'b0, 1'b0, 8'sd0, 8'sd0}
    };

    initial begin
        query_t q;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        jumps_sent = 0;
        nbr_sent = 0;
        rx_hold_req = 0;
        tx_idle = 13;
        rx_idle = 61;
        goal_col = 0;
        goal_row = 0;
        foreach (grid_open[i]) grid_open[i] = 1'b0;

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= jps_pkg::REG_GOAL_X;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_operation  <= jps_pkg::OP_WRITE;
        s_cell_x     <= '0;
        s_cell_y     <= '0;
        s_from_x     <= '0;
        s_from_y     <= '0;
        s_has_parent <= 1'b0;
        s_walkable   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        set_goal(0, 0);
        foreach (plan[i])
            send_word(plan[i].q, plan[i].typed, '{plan[i].ef, plan[i].ex, plan[i].ey, 1'b1});
        drain();

        // sender light, receiver heavy
        set_goal(63, 63);
        random_phase(150);
        drain();

        // sender heavy, receiver light
        tx_idle = 61;
        rx_idle = 13;
        set_goal($urandom_range(0, 15), $urandom_range(0, 15));
        random_phase(150);
        drain();

        // no idling; long receiver hold while full-fan successor queries queue up
        tx_idle = 0;
        rx_idle = 0;
        set_goal(5, 5);
        rx_hold_req = 1;
        for (int i = 0; i < 20; i++) begin
            q = '{jps_pkg::OP_NBR, 8'($urandom_range(1, 14)), 8'($urandom_range(1, 14)),
                  8'sd0, 8'sd0, 1'b0, 1'b0};
            send_word(q);
        end
        random_phase(130);
        drain();
        repeat (200) @(posedge aclk);

        $display("Run covered %0d words (%0d jumps, %0d successor queries), %0d results checked,",
                 words_sent, jumps_sent, nbr_sent, words_checked);
        $display("across four goal settings and three handshake pressure phases.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
design/jps_pkg.sv
design/jps_map.sv
design/jump_point_search_step.sv
tb/tb_jump_point_search_step.sv
